@@ sv/ale_pkg.sv @@
// Package for the array list engine: sizes, codes and item types.
package ale_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_FIND       = 3'd4,
        CMD_CHANGE     = 3'd5
    } t_cmd;

    typedef enum logic [2:0] {
        STS_OK       = 3'd0,
        STS_FULL     = 3'd1,
        STS_EMPTY    = 3'd2,
        STS_BADPOS   = 3'd3,
        STS_NOTFOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] value;
        logic [3:0]         position;
    } t_in_item;

    typedef struct packed {
        t_status    status;
        logic [3:0] match_index;
        logic [4:0] entry_count;
        logic       last;
    } t_out_item;

endpackage

@@ sv/array_list_engine.sv @@
// Array list engine: bounded ordered list of signed words with a walking sequencer.
//
// Usage. An item on the input channel (i_in_valid / o_in_ready, payload
// i_in_item) carries one command: push back, push front, pop back, pop front,
// find or change. Results leave on the output channel (o_out_valid /
// i_out_ready, payload o_out_item). Every command gives one result, except a
// find with matches, which gives one result per matching index in ascending
// order; the last flag marks the final result of each command.
// Throughput. The engine takes one item at a time: o_in_ready is
// high only while it is idle. Push back, pop back, change and unused codes
// execute without a walk. Push front, pop front
// and find walk the stored entries through one memory read port and one
// write port, one entry a cycle while no find match waits to go out, so
// the walk is what sets how long these commands take.
// Reset. A synchronous active-low reset empties the list and drops any result
// held in the output register. The entry memory is not cleared; only entries
// below the count are ever read.
// Stalls. A result is held in the output register until taken. While it waits
// the engine still accepts the next item but holds it before execution until
// the register frees; a find walk also holds while a further match waits.
module array_list_engine (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  ale_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output ale_pkg::t_out_item o_out_item
);
    import ale_pkg::*;

    // Sequencer and command registers
    t_state                 r_state, n_state;
    logic [2:0]             r_cmd;
    logic [DATA_WIDTH-1:0]  r_val;
    logic [3:0]             r_pos;
    logic [CNT_W-1:0]       r_count, n_count;

    // Walk counters: next read address, reads still to issue, and the
    // address of the word now sitting in the read data register
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]       r_left, n_left;
    logic                   r_pend, n_pend;
    logic [IDX_W-1:0]       r_pidx, n_pidx;

    // Find: most recent match, held back until we know whether it is the last
    logic                   r_hit_valid, n_hit_valid;
    logic [IDX_W-1:0]       r_hit_idx, n_hit_idx;

    // Entry memory, one write and one registered read port
    logic [DATA_WIDTH-1:0]  r_mem [CAPACITY];
    logic [DATA_WIDTH-1:0]  r_rdata;
    logic                   mem_we, mem_re;
    logic [IDX_W-1:0]       mem_waddr, mem_raddr;
    logic [DATA_WIDTH-1:0]  mem_wdata;

    // Output register
    logic                   r_out_valid;
    t_out_item              r_out, n_out;
    logic                   emit;

    logic                   out_free;
    logic                   in_fire;
    logic                   hit;
    logic                   stall;
    logic                   full;
    logic                   empty;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign full  = (r_count >= CNT_W'(CAPACITY));
    assign empty = (r_count == '0);
    assign hit   = (r_rdata == r_val);
    // Hold the walk when a held-back match must go out and the register is busy
    assign stall = r_pend && (r_cmd == CMD_FIND) && hit && r_hit_valid && !out_free;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    n_state = S_IDLE;
                    if ((r_cmd == CMD_PUSH_FRONT && !full)
                        || (r_cmd == CMD_POP_FRONT && !empty)
                        || (r_cmd == CMD_FIND && !empty)) begin
                        n_state = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (!stall && r_left == '0) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath controls and results
    always_comb begin
        n_count     = r_count;
        n_idx       = r_idx;
        n_left      = r_left;
        n_pend      = r_pend;
        n_pidx      = r_pidx;
        n_hit_valid = r_hit_valid;
        n_hit_idx   = r_hit_idx;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_pidx;
        mem_raddr   = r_idx;
        mem_wdata   = r_rdata;
        emit        = 1'b0;
        n_out       = r_out;

        unique case (r_state)
            S_IDLE: begin
                n_pend = 1'b0;
            end
            S_EXEC: begin
                if (out_free) begin
                    n_out.status      = STS_OK;
                    n_out.match_index = '0;
                    n_out.last        = 1'b1;
                    emit              = 1'b1;
                    unique case (r_cmd)
                        CMD_PUSH_BACK: begin
                            if (full) begin
                                n_out.status = STS_FULL;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = r_count[IDX_W-1:0];
                                mem_wdata = r_val;
                                n_count   = r_count + 1'b1;
                            end
                        end
                        CMD_PUSH_FRONT: begin
                            if (full) begin
                                n_out.status = STS_FULL;
                            end else begin
                                // walk downwards from the top entry
                                emit   = 1'b0;
                                n_idx  = IDX_W'(r_count - 1'b1);
                                n_left = r_count;
                            end
                        end
                        CMD_POP_BACK: begin
                            if (empty) begin
                                n_out.status = STS_EMPTY;
                            end else begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (empty) begin
                                n_out.status = STS_EMPTY;
                            end else begin
                                emit   = 1'b0;
                                n_idx  = IDX_W'(1);
                                n_left = r_count - 1'b1;
                            end
                        end
                        CMD_FIND: begin
                            if (empty) begin
                                n_out.status = STS_NOTFOUND;
                            end else begin
                                emit        = 1'b0;
                                n_idx       = '0;
                                n_left      = r_count;
                                n_hit_valid = 1'b0;
                            end
                        end
                        CMD_CHANGE: begin
                            if ({1'b0, r_pos} >= r_count) begin
                                n_out.status = STS_BADPOS;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = IDX_W'(r_pos);
                                mem_wdata = r_val;
                            end
                        end
                        default: ;
                    endcase
                    n_out.entry_count = n_count;
                end
            end
            S_WALK: begin
                if (!stall) begin
                    // Issue the next read
                    n_pend = (r_left != '0);
                    if (r_left != '0) begin
                        mem_re = 1'b1;
                        n_left = r_left - 1'b1;
                        n_pidx = r_idx;
                        n_idx  = (r_cmd == CMD_PUSH_FRONT) ? r_idx - 1'b1 : r_idx + 1'b1;
                    end
                    // Retire the word now held in the read data register
                    if (r_pend) begin
                        case (r_cmd)
                            CMD_PUSH_FRONT: begin
                                mem_we    = 1'b1;
                                mem_waddr = r_pidx + 1'b1;
                            end
                            CMD_POP_FRONT: begin
                                mem_we    = 1'b1;
                                mem_waddr = r_pidx - 1'b1;
                            end
                            default: begin
                                if (hit) begin
                                    if (r_hit_valid) begin
                                        emit              = 1'b1;
                                        n_out.status      = STS_OK;
                                        n_out.match_index = 4'(r_hit_idx);
                                        n_out.entry_count = r_count;
                                        n_out.last        = 1'b0;
                                    end
                                    n_hit_valid = 1'b1;
                                    n_hit_idx   = r_pidx;
                                end
                            end
                        endcase
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    emit              = 1'b1;
                    n_out.status      = STS_OK;
                    n_out.match_index = '0;
                    n_out.last        = 1'b1;
                    case (r_cmd)
                        CMD_PUSH_FRONT: begin
                            mem_we    = 1'b1;
                            mem_waddr = '0;
                            mem_wdata = r_val;
                            n_count   = r_count + 1'b1;
                        end
                        CMD_POP_FRONT: begin
                            n_count = r_count - 1'b1;
                        end
                        default: begin
                            if (r_hit_valid) begin
                                n_out.match_index = 4'(r_hit_idx);
                            end else begin
                                n_out.status = STS_NOTFOUND;
                            end
                        end
                    endcase
                    n_out.entry_count = n_count;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
            r_hit_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_hit_valid <= n_hit_valid;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_cmd <= i_in_item.command;
            r_val <= DATA_WIDTH'(i_in_item.value);
            r_pos <= i_in_item.position;
        end
        r_idx     <= n_idx;
        r_left    <= n_left;
        r_pidx    <= n_pidx;
        r_hit_idx <= n_hit_idx;
        if (emit) begin
            r_out <= n_out;
        end
    end

    // Entry memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

endmodule

@@ tb/sv/array_list_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the array list engine: tracks the list, predicts result items, compares.
module array_list_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  ale_pkg::t_in_item  i_in_item,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  ale_pkg::t_out_item i_out_item,
    output int                 o_pending,
    output int                 o_mismatches
);
    import ale_pkg::*;

    logic [DATA_WIDTH-1:0] list_words [CAPACITY];
    int unsigned           list_count;
    t_out_item             owed_results [$];
    int                    mismatches;

    // queue one result item, reporting the count as it stands after the command
    task automatic owe(input t_status st, input int unsigned idx, input logic fin);
        t_out_item r;
        r.status      = st;
        r.match_index = idx[IDX_W-1:0];
        r.entry_count = list_count[CNT_W-1:0];
        r.last        = fin;
        owed_results.push_back(r);
    endtask

    task automatic apply_command(input t_in_item item);
        logic [DATA_WIDTH-1:0] word;
        int unsigned           found [$];
        word = item.value[DATA_WIDTH-1:0];
        case (item.command)
            CMD_PUSH_BACK: begin
                if (list_count >= CAPACITY) begin
                    owe(STS_FULL, 0, 1'b1);
                end else begin
                    list_words[list_count] = word;
                    list_count++;
                    owe(STS_OK, 0, 1'b1);
                end
            end
            CMD_PUSH_FRONT: begin
                if (list_count >= CAPACITY) begin
                    owe(STS_FULL, 0, 1'b1);
                end else begin
                    for (int i = int'(list_count); i > 0; i--)
                        list_words[i] = list_words[i-1];
                    list_words[0] = word;
                    list_count++;
                    owe(STS_OK, 0, 1'b1);
                end
            end
            CMD_POP_BACK: begin
                if (list_count == 0) begin
                    owe(STS_EMPTY, 0, 1'b1);
                end else begin
                    list_count--;
                    owe(STS_OK, 0, 1'b1);
                end
            end
            CMD_POP_FRONT: begin
                if (list_count == 0) begin
                    owe(STS_EMPTY, 0, 1'b1);
                end else begin
                    for (int i = 0; i + 1 < list_count; i++)
                        list_words[i] = list_words[i+1];
                    list_count--;
                    owe(STS_OK, 0, 1'b1);
                end
            end
            CMD_FIND: begin
                for (int i = 0; i < list_count && found.size() < CAPACITY; i++)
                    if (list_words[i] == word)
                        found.push_back(i);
                if (found.size() == 0) begin
                    owe(STS_NOTFOUND, 0, 1'b1);
                end else begin
                    foreach (found[k])
                        owe(STS_OK, found[k], k == found.size() - 1);
                end
            end
            CMD_CHANGE: begin
                if (item.position >= list_count) begin
                    owe(STS_BADPOS, 0, 1'b1);
                end else begin
                    list_words[item.position] = word;
                    owe(STS_OK, 0, 1'b1);
                end
            end
            default: owe(STS_OK, 0, 1'b1);
        endcase
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (owed_results.size() == 0) begin
            if (mismatches < 10)
                $display("%0t: unexpected result: status %0d idx %0d count %0d last %0b",
                         $realtime, got.status, got.match_index, got.entry_count, got.last);
            mismatches++;
        end else begin
            want = owed_results.pop_front();
            if (got.status !== want.status || got.match_index !== want.match_index ||
                got.entry_count !== want.entry_count || got.last !== want.last) begin
                if (mismatches < 10)
                    $display("%0t: mismatch: want status %0d idx %0d count %0d last %0b, %s",
                             $realtime, want.status, want.match_index, want.entry_count,
                             want.last, $sformatf("got status %0d idx %0d count %0d last %0b",
                             got.status, got.match_index, got.entry_count, got.last));
                mismatches++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            list_count = 0;
            owed_results.delete();
        end else begin
            if (i_out_valid && i_out_ready)
                check_result(i_out_item);
            if (i_in_valid && i_in_ready)
                apply_command(i_in_item);
        end
        o_pending    <= owed_results.size();
        o_mismatches <= mismatches;
    end

endmodule

@@ tb/sv/array_list_engine_test.sv @@
`timescale 1ns / 1ps
// Top of the array list engine test: stimulus, handshake pacing and verdict.
module array_list_engine_test;
    import ale_pkg::*;

    // Command codes the package leaves unnamed; the engine must treat them as no-ops
    localparam logic [2:0] CMD_SPARE_6 = 3'd6;
    localparam logic [2:0] CMD_SPARE_7 = 3'd7;

    localparam logic [31:0] WORD_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN  = 32'h8000_0000;
    localparam logic [31:0] WORD_ONES = 32'hFFFF_FFFF;

    localparam int TOTAL_ITEMS      = 450;
    localparam int LONG_HOLD_AT     = 80;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES      = 40;
    // Worst case: every find yielding 16 result items, each waiting out a long
    // receiver stall, plus sender gaps and the walk itself, taken several times over
    localparam int CYCLE_LIMIT      = 600_000;

    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED,
        PH_SAME
    } t_phase;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    t_in_item  in_item   = '0;
    logic      out_ready = 1'b0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;

    int pending;
    int mismatches;
    int items_sent  = 0;
    int burst_left  = 1;
    int cycle_count = 0;

    array_list_engine uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    array_list_checker scoreboard (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .o_pending    (pending),
        .o_mismatches (mismatches)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Cycle counter and watchdog: a hung handshake ends the run here
    always @(posedge clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Offer one item and hold it until the engine takes it. Between bursts,
    // drop valid for a random gap; some bursts run long with no gap at all.
    task automatic paced_send(input t_in_item item);
        int gap;
        in_valid <= 1'b1;
        in_item  <= item;
        do @(posedge clk); while (!in_ready);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 8);
        end
    endtask

    task automatic issue(input logic [2:0] code, input logic [31:0] word,
                         input logic [3:0] slot);
        t_in_item item;
        item.command  = code;
        item.value    = word;
        item.position = slot;
        paced_send(item);
    endtask

    // Stop offering items until every owed result item has come back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Lean on extremes and a few tiny values so that finds hit repeatedly;
    // the rest is fully random so every value bit toggles.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return WORD_ONES;
            3:       return 32'd0;
            4, 5:    return 32'($urandom_range(1, 3));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [2:0] pick_command(input t_phase ph);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        case (ph)
            PH_FILL, PH_SAME: begin
                if (roll < 35)      return CMD_PUSH_BACK;
                else if (roll < 65) return CMD_PUSH_FRONT;
                else if (roll < 78) return CMD_FIND;
                else if (roll < 88) return CMD_CHANGE;
                else if (roll < 91) return CMD_POP_BACK;
                else if (roll < 94) return CMD_POP_FRONT;
                else                return roll[0] ? CMD_SPARE_7 : CMD_SPARE_6;
            end
            PH_DRAIN: begin
                if (roll < 30)      return CMD_POP_BACK;
                else if (roll < 60) return CMD_POP_FRONT;
                else if (roll < 72) return CMD_FIND;
                else if (roll < 82) return CMD_CHANGE;
                else if (roll < 87) return CMD_PUSH_BACK;
                else if (roll < 92) return CMD_PUSH_FRONT;
                else                return roll[0] ? CMD_SPARE_7 : CMD_SPARE_6;
            end
            default: begin
                if (roll < 94)      return 3'($urandom_range(0, 5));
                else                return roll[0] ? CMD_SPARE_7 : CMD_SPARE_6;
            end
        endcase
    endfunction

    // Receiver: cycle through ready patterns of its own, and once, part way
    // through the random items, hold off long enough to back the engine up.
    initial begin
        int unsigned mode;
        int unsigned span;
        int unsigned held;
        logic [7:0]  ring;
        bit          long_done;
        long_done = 1'b0;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (!long_done && items_sent >= LONG_HOLD_AT) begin
                long_done = 1'b1;
                out_ready <= 1'b0;
                for (held = 0; held < LONG_HOLD_CYCLES; held++)
                    @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            ring = $urandom();
            if (ring == 8'h00)
                ring = 8'h5A;
            for (span = 0; span < 48; span++) begin
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= 1'($urandom_range(0, 1));
                    2: begin
                        out_ready <= ring[0];
                        ring = {ring[0], ring[7:1]};
                    end
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial begin
        t_in_item    item;
        t_phase      ph;
        logic [31:0] same_word;
        int          phase_len;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: removals, find and change on an empty list first
        issue(CMD_POP_BACK,   32'd0,       4'd0);
        issue(CMD_POP_FRONT,  32'd0,       4'd0);
        issue(CMD_FIND,       32'd0,       4'd0);
        issue(CMD_CHANGE,     WORD_ONES,   4'd0);
        // Build [0, MIN, MAX, -1, -1] from both ends
        issue(CMD_PUSH_BACK,  WORD_MAX,    4'd0);
        issue(CMD_PUSH_FRONT, WORD_MIN,    4'd0);
        issue(CMD_PUSH_BACK,  WORD_ONES,   4'd0);
        issue(CMD_PUSH_FRONT, 32'd0,       4'd0);
        issue(CMD_PUSH_BACK,  WORD_ONES,   4'd0);
        // Find with two matches and with one
        issue(CMD_FIND,       WORD_ONES,   4'd0);
        issue(CMD_FIND,       WORD_MIN,    4'd0);
        // Change beyond the count, then at the last held entry
        issue(CMD_CHANGE,     32'd0,       4'd15);
        issue(CMD_CHANGE,     WORD_MAX,    4'd4);
        issue(CMD_FIND,       WORD_MAX,    4'd0);
        // Unused codes leave the list alone
        issue(CMD_SPARE_6,    32'd0,       4'd0);
        issue(CMD_SPARE_7,    WORD_ONES,   4'd15);
        issue(CMD_POP_FRONT,  32'd0,       4'd0);
        issue(CMD_POP_BACK,   32'd0,       4'd0);
        issue(CMD_FIND,       32'd12345,   4'd0);
        issue(CMD_CHANGE,     32'h5A5A5A5A, 4'd0);
        issue(CMD_FIND,       32'h5A5A5A5A, 4'd0);
        // Empty it again and try one removal too many
        issue(CMD_POP_FRONT,  32'd0,       4'd0);
        issue(CMD_POP_FRONT,  32'd0,       4'd0);
        issue(CMD_POP_BACK,   32'd0,       4'd0);
        issue(CMD_POP_FRONT,  32'd0,       4'd0);

        wait_for_drain();

        // Random phases: filling runs reach the full list, draining runs the
        // empty one, and same-value runs give finds with many matches.
        while (items_sent < TOTAL_ITEMS) begin
            ph        = t_phase'($urandom_range(0, 3));
            same_word = pick_value();
            phase_len = $urandom_range(15, 50);
            if ($urandom_range(0, 3) == 0)
                wait_for_drain();
            for (int k = 0; k < phase_len && items_sent < TOTAL_ITEMS; k++) begin
                item.command  = pick_command(ph);
                item.value    = (ph == PH_SAME && $urandom_range(0, 9) != 0) ? same_word
                                                                             : pick_value();
                item.position = $urandom_range(0, 15);
                paced_send(item);
            end
        end

        // Let the last result items come home, then allow a few walks' worth of slack
        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
